// ----- rtl/tcce_pkg.sv -----
// Shared sizes, character codes, cursor and result types for the text console cursor engine.
package tcce_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 5;

  localparam int SCREEN_CELLS   = COLS * ROWS;
  localparam int LAST_ROW_START = COLS * (ROWS - 1);

  localparam int POS_W  = $clog2(SCREEN_CELLS + 1);
  localparam int COL_W  = $clog2(COLS);
  localparam int TM_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int STEP_W = $clog2(TAB_STOP + 1) > 0 ? $clog2(TAB_STOP + 1) : 1;
  localparam int SUM_W  = $clog2(COLS + TAB_STOP);
  localparam int IDX_W  = 11;

  // Upper bound of row wraps a single tab step can cause in the column counter.
  localparam int COL_WRAPS = (COLS - 1 + TAB_STOP) / COLS;

  localparam int LAST_TMOD   = LAST_ROW_START % TAB_STOP;
  localparam int SCREEN_TMOD = SCREEN_CELLS % TAB_STOP;

  localparam logic [7:0] ATTR_RESET = 8'd7;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  typedef logic [COLS-1:0][TM_W-1:0] col_tab_t;

  // Cursor kept as linear position plus its column and its phase within a tab stop.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] col;
    logic [TM_W-1:0]  tmod;
  } cursor_t;

  typedef struct packed {
    logic             cell_write;
    logic [IDX_W-1:0] cell_index;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attribute;
    logic             scroll_up;
    logic [IDX_W-1:0] cursor_after;
  } result_t;

  // Table of (COLS - col) mod TAB_STOP, the tab phase gained by a newline.
  function automatic col_tab_t make_back_table();
    col_tab_t t;
    for (int i = 0; i < COLS; i++) begin
      t[i] = TM_W'((COLS - i) % TAB_STOP);
    end
    return t;
  endfunction

  // Table of col mod TAB_STOP, the tab phase lost by a carriage return.
  function automatic col_tab_t make_col_table();
    col_tab_t t;
    for (int i = 0; i < COLS; i++) begin
      t[i] = TM_W'(i % TAB_STOP);
    end
    return t;
  endfunction

  localparam col_tab_t BACK_MOD = make_back_table();
  localparam col_tab_t COL_MOD  = make_col_table();

endpackage

// ----- rtl/text_console_cursor_engine_unit.sv -----
// Top level of the text console cursor engine: input register, cursor state, result register.
// A word accepted into the input register passes through the cursor step into the result register.
// One character word per cycle while the output is not stalled; the cursor register updates with each word.
// While a result waits on a stalled output, the input register takes one more word, then stalls.
// Reset (rst_ni low, asynchronous) empties both registers, puts the cursor at the top
// left cell and sets the text attribute to 7.
module text_console_cursor_engine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_text_attribute_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic        cell_write_o,
  output logic [10:0] cell_index_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attribute_o,
  output logic        scroll_up_o,
  output logic [10:0] cursor_after_o
);

  logic              in_valid_q;
  logic [7:0]        char_q;
  logic              out_valid_q;
  tcce_pkg::result_t res_q;
  tcce_pkg::result_t res_d;
  tcce_pkg::cursor_t cur_q;
  tcce_pkg::cursor_t cur_d;
  logic [7:0]        attr_q;
  logic              adv;

  assign adv         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !adv;
  assign cfg_ready_o = 1'b1;

  tcce_cursor_step u_step (
    .cur_i       (cur_q),
    .char_code_i (char_q),
    .attr_i      (attr_q),
    .nxt_o       (cur_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      attr_q      <= tcce_pkg::ATTR_RESET;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        cur_q       <= cur_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_text_attribute_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_write_o     = res_q.cell_write;
  assign cell_index_o     = res_q.cell_index;
  assign cell_char_o      = res_q.cell_char;
  assign cell_attribute_o = res_q.cell_attribute;
  assign scroll_up_o      = res_q.scroll_up;
  assign cursor_after_o   = res_q.cursor_after;

endmodule

// ----- rtl/tcce_cursor_step.sv -----
// Combinational cursor update and result formation for one character.
module tcce_cursor_step (
  input  tcce_pkg::cursor_t cur_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        attr_i,
  output tcce_pkg::cursor_t nxt_o,
  output tcce_pkg::result_t res_o
);

  tcce_pkg::cursor_t                  base;
  logic                               scroll;
  logic [tcce_pkg::STEP_W-1:0]        tab_step;
  logic [tcce_pkg::POS_W:0]           tab_pos;
  logic                               tab_sat;
  logic [tcce_pkg::SUM_W-1:0]         tab_col;
  logic [tcce_pkg::TM_W:0]            nl_tm;
  logic [tcce_pkg::TM_W:0]            cr_tm;
  logic [tcce_pkg::TM_W-1:0]          cr_cm;

  // A cursor at the screen end first moves to the last row start and scrolls.
  always_comb begin
    if (cur_i.pos >= tcce_pkg::POS_W'(tcce_pkg::SCREEN_CELLS)) begin
      base.pos  = tcce_pkg::POS_W'(tcce_pkg::LAST_ROW_START);
      base.col  = '0;
      base.tmod = tcce_pkg::TM_W'(tcce_pkg::LAST_TMOD);
      scroll    = 1'b1;
    end else begin
      base   = cur_i;
      scroll = 1'b0;
    end
  end

  always_comb begin
    tab_step = tcce_pkg::STEP_W'(tcce_pkg::TAB_STOP) - tcce_pkg::STEP_W'(base.tmod);
    tab_pos  = {1'b0, base.pos} + (tcce_pkg::POS_W + 1)'(tab_step);
    tab_sat  = tab_pos > (tcce_pkg::POS_W + 1)'(tcce_pkg::SCREEN_CELLS);
    tab_col  = tcce_pkg::SUM_W'(base.col) + tcce_pkg::SUM_W'(tab_step);
    for (int i = 0; i < tcce_pkg::COL_WRAPS; i++) begin
      if (tab_col >= tcce_pkg::SUM_W'(tcce_pkg::COLS)) begin
        tab_col = tab_col - tcce_pkg::SUM_W'(tcce_pkg::COLS);
      end
    end
  end

  always_comb begin
    nl_tm = (tcce_pkg::TM_W + 1)'(base.tmod)
          + (tcce_pkg::TM_W + 1)'(tcce_pkg::BACK_MOD[base.col]);
    if (nl_tm >= (tcce_pkg::TM_W + 1)'(tcce_pkg::TAB_STOP)) begin
      nl_tm = nl_tm - (tcce_pkg::TM_W + 1)'(tcce_pkg::TAB_STOP);
    end
    cr_cm = tcce_pkg::COL_MOD[base.col];
    if (base.tmod >= cr_cm) begin
      cr_tm = (tcce_pkg::TM_W + 1)'(base.tmod) - (tcce_pkg::TM_W + 1)'(cr_cm);
    end else begin
      cr_tm = (tcce_pkg::TM_W + 1)'(base.tmod) + (tcce_pkg::TM_W + 1)'(tcce_pkg::TAB_STOP)
            - (tcce_pkg::TM_W + 1)'(cr_cm);
    end
  end

  always_comb begin
    nxt_o = base;
    res_o = '0;
    res_o.scroll_up = scroll;
    case (char_code_i)
      tcce_pkg::CH_NEWLINE: begin
        nxt_o.pos  = base.pos + tcce_pkg::POS_W'(tcce_pkg::COLS) - tcce_pkg::POS_W'(base.col);
        nxt_o.col  = '0;
        nxt_o.tmod = tcce_pkg::TM_W'(nl_tm);
      end
      tcce_pkg::CH_TAB: begin
        if (tab_sat) begin
          nxt_o.pos  = tcce_pkg::POS_W'(tcce_pkg::SCREEN_CELLS);
          nxt_o.col  = '0;
          nxt_o.tmod = tcce_pkg::TM_W'(tcce_pkg::SCREEN_TMOD);
        end else begin
          nxt_o.pos  = tab_pos[tcce_pkg::POS_W-1:0];
          nxt_o.col  = tcce_pkg::COL_W'(tab_col);
          nxt_o.tmod = '0;
        end
      end
      tcce_pkg::CH_RETURN: begin
        nxt_o.pos  = base.pos - tcce_pkg::POS_W'(base.col);
        nxt_o.col  = '0;
        nxt_o.tmod = tcce_pkg::TM_W'(cr_tm);
      end
      tcce_pkg::CH_BACKSPACE: begin
        // The cursor is clamped at the top left cell.
        if (base.pos != '0) begin
          nxt_o.pos  = base.pos - 1'b1;
          nxt_o.col  = (base.col == '0) ? tcce_pkg::COL_W'(tcce_pkg::COLS - 1)
                                        : base.col - 1'b1;
          nxt_o.tmod = (base.tmod == '0) ? tcce_pkg::TM_W'(tcce_pkg::TAB_STOP - 1)
                                         : base.tmod - 1'b1;
        end
      end
      default: begin
        res_o.cell_write     = 1'b1;
        res_o.cell_index     = tcce_pkg::IDX_W'(base.pos);
        res_o.cell_char      = char_code_i;
        res_o.cell_attribute = attr_i;
        nxt_o.pos  = base.pos + 1'b1;
        nxt_o.col  = (base.col == tcce_pkg::COL_W'(tcce_pkg::COLS - 1)) ? '0
                                                                      : base.col + 1'b1;
        nxt_o.tmod = (base.tmod == tcce_pkg::TM_W'(tcce_pkg::TAB_STOP - 1)) ? '0
                                                                           : base.tmod + 1'b1;
      end
    endcase
    res_o.cursor_after = tcce_pkg::IDX_W'(nxt_o.pos);
  end

endmodule

// ----- rtl/tcce_checker.sv -----
// Port-level checks for the text console cursor engine, bound to the top level.
module tcce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        cell_write_o,
  input logic [10:0] cell_index_o,
  input logic [7:0]  cell_char_o,
  input logic [7:0]  cell_attribute_o,
  input logic        scroll_up_o,
  input logic [10:0] cursor_after_o
);

  // A stalled result word stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_index_o)
      && $stable(cursor_after_o) && $stable(cell_write_o) && $stable(scroll_up_o))
    else $error("stalled result word changed");

  // Control characters write no cell, so the cell fields are all zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cell_write_o |-> cell_index_o == '0 && cell_char_o == '0
      && cell_attribute_o == '0)
    else $error("cell fields set without a cell write");

  // A printable character advances the cursor by one past the written cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_write_o |-> cursor_after_o == cell_index_o + 11'd1)
    else $error("cursor did not advance past the written cell");

  // After a scroll the write lands at the start of the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_write_o && scroll_up_o
      |-> cell_index_o == 11'(tcce_pkg::LAST_ROW_START))
    else $error("scrolled write not at last row start");

  // The input stalls only behind a result word that is itself stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output drains");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);

// ----- verif/tb_text_console_cursor_engine_unit.sv -----
// Self-checking testbench for the text console cursor engine: cursor tracking, cell writes and scrolling.
module tb_text_console_cursor_engine_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_WORDS    = 154;
  localparam int OPENING_WORDS  = 18;

  typedef struct {
    logic [7:0]        ch;
    tcce_pkg::result_t res;
  } cell_expect_t;

  // Tracks the cursor and the attribute register and holds the results still owed by the block.
  class cursor_tracker;
    int           cursor;
    logic [7:0]   attribute;
    int           errors;
    cell_expect_t pending_cells[$];

    function new();
      cursor    = 0;
      attribute = tcce_pkg::ATTR_RESET;
      errors    = 0;
    endfunction

    function void set_attribute(logic [7:0] a);
      attribute = a;
    endfunction

    function int pending();
      return pending_cells.size();
    endfunction

    function void note_char(logic [7:0] ch);
      cell_expect_t e;
      int           p;
      p     = cursor;
      e.ch  = ch;
      e.res = '0;
      // A cursor parked at the screen end scrolls first, whatever the character is.
      if (p >= tcce_pkg::SCREEN_CELLS) begin
        p = tcce_pkg::LAST_ROW_START;
        e.res.scroll_up = 1'b1;
      end
      case (ch)
        tcce_pkg::CH_NEWLINE: p = p + (tcce_pkg::COLS - p % tcce_pkg::COLS);
        tcce_pkg::CH_TAB: begin
          p = p + (tcce_pkg::TAB_STOP - p % tcce_pkg::TAB_STOP);
          if (p > tcce_pkg::SCREEN_CELLS) p = tcce_pkg::SCREEN_CELLS;
        end
        tcce_pkg::CH_RETURN: p = p - p % tcce_pkg::COLS;
        tcce_pkg::CH_BACKSPACE: if (p > 0) p = p - 1;
        default: begin
          e.res.cell_write     = 1'b1;
          e.res.cell_index     = tcce_pkg::IDX_W'(p);
          e.res.cell_char      = ch;
          e.res.cell_attribute = attribute;
          p = p + 1;
        end
      endcase
      cursor = p;
      e.res.cursor_after = tcce_pkg::IDX_W'(p);
      pending_cells.push_back(e);
    endfunction

    task report(string what);
      errors++;
      $display("%0t: cell result mismatch: %s", $time, what);
    endtask

    task compare_field(string field, logic [7:0] ch, int got, int want);
      if (got != want)
        report($sformatf("char %02h %s got %0d expected %0d", ch, field, got, want));
    endtask

    task check_result(tcce_pkg::result_t got);
      cell_expect_t e;
      if (pending_cells.size() == 0) begin
        report($sformatf("unexpected word, cursor_after %0d", got.cursor_after));
      end else begin
        e = pending_cells.pop_front();
        compare_field("cell_write", e.ch, int'(got.cell_write), int'(e.res.cell_write));
        compare_field("cell_index", e.ch, int'(got.cell_index), int'(e.res.cell_index));
        compare_field("cell_char", e.ch, int'(got.cell_char), int'(e.res.cell_char));
        compare_field("cell_attribute", e.ch, int'(got.cell_attribute),
                      int'(e.res.cell_attribute));
        compare_field("scroll_up", e.ch, int'(got.scroll_up), int'(e.res.scroll_up));
        compare_field("cursor_after", e.ch, int'(got.cursor_after),
                      int'(e.res.cursor_after));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_code_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_text_attribute_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        cell_write_o;
  logic [10:0] cell_index_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attribute_o;
  logic        scroll_up_o;
  logic [10:0] cursor_after_o;

  cursor_tracker tracker = new();
  int in_idle_pct;
  int out_stall_pct;
  int quiet_cycles;

  text_console_cursor_engine_unit uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .char_code_i          (char_code_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_text_attribute_i (cfg_text_attribute_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .cell_write_o         (cell_write_o),
    .cell_index_o         (cell_index_o),
    .cell_char_o          (cell_char_o),
    .cell_attribute_o     (cell_attribute_o),
    .scroll_up_o          (scroll_up_o),
    .cursor_after_o       (cursor_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Checks results and watches for a hung handshake.
  always @(posedge clk_i) begin
    tcce_pkg::result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cell_write     = cell_write_o;
      got.cell_index     = cell_index_o;
      got.cell_char      = cell_char_o;
      got.cell_attribute = cell_attribute_o;
      got.scroll_up      = scroll_up_o;
      got.cursor_after   = cursor_after_o;
      tracker.check_result(got);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_text_console_cursor_engine_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_char(input logic [7:0] ch);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_char(ch);
  endtask

  task write_attribute(input logic [7:0] a);
    @(negedge clk_i);
    in_valid_i           <= 1'b0;
    cfg_valid_i          <= 1'b1;
    cfg_text_attribute_i <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_attribute(a);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The last word was taken at a rising edge, so valid drops before waiting.
  task drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly control codes and printable text, with some arbitrary bytes as noise.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) return tcce_pkg::CH_NEWLINE;
    if (r < 25) return tcce_pkg::CH_TAB;
    if (r < 33) return tcce_pkg::CH_RETURN;
    if (r < 41) return tcce_pkg::CH_BACKSPACE;
    if (r < 80) return 8'($urandom_range(8'h7E, 8'h20));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [7:0] attr_plan [PHASE_COUNT];
    logic [7:0] opening [OPENING_WORDS];
    int         sent;
    int         run;
    int         r;

    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    char_code_i          = 8'h00;
    cfg_valid_i          = 1'b0;
    cfg_text_attribute_i = 8'h00;
    out_stall_i          = 1'b0;
    in_idle_pct          = 0;
    out_stall_pct        = 0;
    quiet_cycles         = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Backspace at the top left cell must clamp; the rest covers byte extremes and each control.
    opening = '{tcce_pkg::CH_BACKSPACE, 8'h00, 8'hFF, tcce_pkg::CH_BACKSPACE, tcce_pkg::CH_TAB,
                8'h41, tcce_pkg::CH_TAB, tcce_pkg::CH_TAB, tcce_pkg::CH_RETURN, 8'h80, 8'h7F,
                tcce_pkg::CH_NEWLINE, 8'h55, 8'hAA, tcce_pkg::CH_BACKSPACE,
                tcce_pkg::CH_RETURN, tcce_pkg::CH_BACKSPACE, tcce_pkg::CH_NEWLINE};
    foreach (opening[i]) send_char(opening[i]);

    attr_plan = '{8'h00, 8'hFF, tcce_pkg::ATTR_RESET, 8'($urandom_range(255)), 8'h80, 8'h7F,
                  8'($urandom_range(255)), 8'($urandom_range(255))};

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      write_attribute(attr_plan[phase]);
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 48; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 48; end
        default: begin in_idle_pct = 20; out_stall_pct = 20; end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // A run of newlines can walk the cursor to the screen end and into a scroll.
          run = $urandom_range(27, 20);
          repeat (run) send_char(tcce_pkg::CH_NEWLINE);
          send_char(pick_char());
          sent += run + 1;
        end else if (r < 12) begin
          run = $urandom_range(20, 8);
          repeat (run) send_char(tcce_pkg::CH_TAB);
          sent += run;
        end else begin
          send_char(pick_char());
          sent++;
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb_text_console_cursor_engine_unit passed");
    end else begin
      $display("tb_text_console_cursor_engine_unit failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tcce_pkg.sv
rtl/tcce_cursor_step.sv
rtl/text_console_cursor_engine_unit.sv
rtl/tcce_checker.sv
verif/tb_text_console_cursor_engine_unit.sv
